// ----- rtl/met_pkg.sv -----
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, codes and helpers for the mouse event tracker.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam logic [16:0] DEF_BOUND_X = 17'd640;
    localparam logic [16:0] DEF_BOUND_Y = 17'd480;
    localparam logic [16:0] BOUND_MAX   = 17'd65536;

    localparam logic [1:0] CFG_BOUNDS_X = 2'd0;
    localparam logic [1:0] CFG_BOUNDS_Y = 2'd1;

    typedef enum logic [3:0] {
        OP_POSITION = 4'd0,
        OP_MOTION   = 4'd1,
        OP_DOWN     = 4'd2,
        OP_UP       = 4'd3,
        OP_WHEEL    = 4'd4,
        OP_HELD     = 4'd5,
        OP_PRESSED  = 4'd6,
        OP_POS      = 4'd7,
        OP_DELTA    = 4'd8,
        OP_WHEELX   = 4'd9,
        OP_WHEELY   = 4'd10,
        OP_PEEK     = 4'd11,
        OP_GET      = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        EV_DOWN     = 3'd0,
        EV_UP       = 3'd1,
        EV_POSITION = 3'd2,
        EV_MOTION   = 3'd3,
        EV_WHEEL    = 3'd4
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // per-axis update selects
    typedef struct packed {
        logic position;
        logic motion;
    } t_axis_ctl;

    // one queue entry as stored in RAM
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] stamp;
        logic [7:0]  buttons;
        logic [16:0] y;
        logic [16:0] x;
    } t_record;

    localparam int REC_W = $bits(t_record);

    // zero raised to one, anything above the max cut down to it
    function automatic logic [16:0] fix_bound(input logic [16:0] v);
        logic [16:0] r;
        if (v == 17'd0) begin
            r = 17'd1;
        end else if (v > BOUND_MAX) begin
            r = BOUND_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/met_ram.sv -----
// ----------------------------------------------------------------------------
// met_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module met_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/met_axis.sv -----
// ----------------------------------------------------------------------------
// met_axis
// One cursor axis: clamped position/motion update and motion-sum increment.
// ----------------------------------------------------------------------------
module met_axis
    import met_pkg::*;
(
    input  t_axis_ctl          i_ctl,
    input  logic signed [16:0] i_value,
    input  logic [16:0]        i_bound,
    input  logic [15:0]        i_cursor,
    output logic [15:0]        o_cursor,
    output logic [31:0]        o_sum_inc
);

    logic [31:0] v32;
    logic [31:0] bound32;
    logic [31:0] cur32;
    logic [31:0] moved;
    logic [16:0] top;

    assign v32     = {{15{i_value[16]}}, i_value};
    assign bound32 = {15'd0, i_bound};
    assign cur32   = {16'd0, i_cursor};
    assign moved   = cur32 + v32;
    assign top     = i_bound - 17'd1;

    always_comb begin
        o_cursor  = i_cursor;
        o_sum_inc = 32'd0;
        if (i_ctl.position) begin
            // sum takes the raw jump; negatives compare as huge and clamp
            o_sum_inc = v32 - cur32;
            o_cursor  = (v32 >= bound32) ? top[15:0] : v32[15:0];
        end else if (i_ctl.motion) begin
            o_sum_inc = v32;
            if (moved >= bound32) begin
                o_cursor = v32[31] ? 16'd0 : top[15:0];
            end else begin
                o_cursor = moved[15:0];
            end
        end
    end

endmodule

// ----- rtl/mouse_event_tracker.sv -----
// ----------------------------------------------------------------------------
// mouse_event_tracker
// Cursor, delta, wheel and button tracking with a RAM-backed event queue.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        request    i_in_valid / o_in_stall   operation, values, mask, stamps
//  out       result     o_out_valid / i_out_stall status, kind, time, x, y, buttons
//  cfg       write      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Posts, value reads and unused codes: result registered at accept.
//  Peek/get with events pending: result formed from the registered RAM read.
//  Input stalls while a queue read is in flight or a result is held stalled.
//  Synchronous active-low reset; queue RAM content is not cleared.
// ----------------------------------------------------------------------------
module mouse_event_tracker
    import met_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_operation,
    input  logic signed [16:0] i_value_x,
    input  logic signed [16:0] i_value_y,
    input  logic [7:0]         i_button_mask,
    input  logic [31:0]        i_stamp_ms,
    input  logic [31:0]        i_now_ms,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_status,
    output logic [2:0]         o_event_kind,
    output logic [31:0]        o_event_time,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic [7:0]         o_out_buttons,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    t_state        r_state, n_state;
    logic [16:0]   r_bound_x, n_bound_x, r_bound_y, n_bound_y;
    logic [15:0]   r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [31:0]   r_msum_x, n_msum_x, r_msum_y, n_msum_y;
    logic [31:0]   r_wsum_x, n_wsum_x, r_wsum_y, n_wsum_y;
    logic [7:0]    r_held, n_held, r_pressed, n_pressed;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;

    logic          r_out_valid;
    logic          r_status;
    logic [2:0]    r_kind;
    logic [31:0]   r_time, r_x, r_y;
    logic [7:0]    r_btn;

    logic          in_acc, busy;
    t_op           op;
    logic [AW-1:0] tail_next;
    logic          q_full, q_empty, is_post, go_read;
    logic [31:0]   stamp, vx32, vy32;

    t_axis_ctl     ax_ctl;
    logic [15:0]   ax_cur_x, ax_cur_y;
    logic [31:0]   ax_inc_x, ax_inc_y;

    logic          ram_we;
    t_record       wrec, rrec;
    logic [REC_W-1:0] ram_rdata;

    logic          res_load, res_status;
    logic [2:0]    res_kind;
    logic [31:0]   res_time, res_x, res_y;
    logic [7:0]    res_btn;
    logic [16:0]   cfg_bound;

    assign op        = t_op'(i_operation);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign tail_next = (r_tail == LAST) ? '0 : r_tail + AW'(1);
    assign q_full    = (tail_next == r_head);
    assign q_empty   = (r_head == r_tail);
    assign is_post   = (i_operation inside {[OP_POSITION:OP_WHEEL]});
    assign go_read   = in_acc && (op == OP_PEEK || op == OP_GET) && !q_empty;
    assign stamp     = (i_stamp_ms == 32'd0) ? i_now_ms : i_stamp_ms;
    assign vx32      = {{15{i_value_x[16]}}, i_value_x};
    assign vy32      = {{15{i_value_y[16]}}, i_value_y};
    assign cfg_bound = fix_bound(i_cfg_data);
    assign o_cfg_ready = 1'b1;

    assign ax_ctl.position = (op == OP_POSITION);
    assign ax_ctl.motion   = (op == OP_MOTION);

    met_axis u_axis_x (
        .i_ctl     (ax_ctl),
        .i_value   (i_value_x),
        .i_bound   (r_bound_x),
        .i_cursor  (r_cur_x),
        .o_cursor  (ax_cur_x),
        .o_sum_inc (ax_inc_x)
    );

    met_axis u_axis_y (
        .i_ctl     (ax_ctl),
        .i_value   (i_value_y),
        .i_bound   (r_bound_y),
        .i_cursor  (r_cur_y),
        .o_cursor  (ax_cur_y),
        .o_sum_inc (ax_inc_y)
    );

    met_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (wrec),
        .i_re    (go_read),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign rrec = t_record'(ram_rdata);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (go_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy = 1'b0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_READ: busy = 1'b1;
            default: busy = 1'b1;
        endcase
        o_in_stall = busy || (r_out_valid && i_out_stall);
    end

    // state update and result forming
    always_comb begin
        n_bound_x = r_bound_x;
        n_bound_y = r_bound_y;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_msum_x  = r_msum_x;
        n_msum_y  = r_msum_y;
        n_wsum_x  = r_wsum_x;
        n_wsum_y  = r_wsum_y;
        n_held    = r_held;
        n_pressed = r_pressed;
        n_head    = r_head;
        n_tail    = r_tail;

        ram_we       = 1'b0;
        wrec         = '0;
        wrec.stamp   = stamp;

        res_load   = 1'b0;
        res_status = 1'b0;
        res_kind   = 3'd0;
        res_time   = 32'd0;
        res_x      = 32'd0;
        res_y      = 32'd0;
        res_btn    = 8'd0;

        if (in_acc) begin
            if (is_post) begin
                res_load = 1'b1;
                if (q_full) begin
                    res_status = 1'b1;
                end else begin
                    ram_we = 1'b1;
                    n_tail = tail_next;
                    case (op)
                        OP_POSITION: begin
                            wrec.kind = EV_POSITION;
                            n_cur_x   = ax_cur_x;
                            n_cur_y   = ax_cur_y;
                            n_msum_x  = r_msum_x + ax_inc_x;
                            n_msum_y  = r_msum_y + ax_inc_y;
                            wrec.x    = {1'b0, ax_cur_x};
                            wrec.y    = {1'b0, ax_cur_y};
                        end
                        OP_MOTION: begin
                            wrec.kind = EV_MOTION;
                            n_cur_x   = ax_cur_x;
                            n_cur_y   = ax_cur_y;
                            n_msum_x  = r_msum_x + ax_inc_x;
                            n_msum_y  = r_msum_y + ax_inc_y;
                            wrec.x    = i_value_x;
                            wrec.y    = i_value_y;
                        end
                        OP_DOWN: begin
                            wrec.kind    = EV_DOWN;
                            wrec.x       = {1'b0, r_cur_x};
                            wrec.y       = {1'b0, r_cur_y};
                            wrec.buttons = i_button_mask;
                            n_held       = r_held | i_button_mask;
                            n_pressed    = r_pressed | i_button_mask;
                        end
                        OP_UP: begin
                            wrec.kind    = EV_UP;
                            wrec.x       = {1'b0, r_cur_x};
                            wrec.y       = {1'b0, r_cur_y};
                            wrec.buttons = i_button_mask;
                            n_held       = r_held & ~i_button_mask;
                        end
                        default: begin
                            wrec.kind = EV_WHEEL;
                            n_wsum_x  = r_wsum_x + vx32;
                            n_wsum_y  = r_wsum_y + vy32;
                            wrec.x    = i_value_x;
                            wrec.y    = i_value_y;
                        end
                    endcase
                end
            end else if (i_operation inside {[OP_HELD:OP_WHEELY]}) begin
                // value reads flush the queue
                res_load = 1'b1;
                n_head   = '0;
                n_tail   = '0;
                case (op)
                    OP_HELD: res_btn = r_held;
                    OP_PRESSED: begin
                        res_btn   = r_pressed;
                        n_pressed = 8'd0;
                    end
                    OP_POS: begin
                        res_x = {16'd0, r_cur_x};
                        res_y = {16'd0, r_cur_y};
                    end
                    OP_DELTA: begin
                        res_x    = r_msum_x;
                        res_y    = r_msum_y;
                        n_msum_x = 32'd0;
                        n_msum_y = 32'd0;
                    end
                    OP_WHEELX: begin
                        res_x    = r_wsum_x;
                        n_wsum_x = 32'd0;
                    end
                    default: begin
                        res_x    = r_wsum_y;
                        n_wsum_y = 32'd0;
                    end
                endcase
            end else if (op == OP_PEEK || op == OP_GET) begin
                if (q_empty) begin
                    res_load   = 1'b1;
                    res_status = 1'b1;
                end else if (op == OP_GET) begin
                    // head read is already addressed this cycle
                    n_head = (r_head == LAST) ? '0 : r_head + AW'(1);
                end
            end else begin
                res_load = 1'b1;
            end
        end

        if (r_state == ST_READ) begin
            res_load = 1'b1;
            res_kind = rrec.kind;
            res_time = rrec.stamp;
            res_btn  = rrec.buttons;
            res_x    = {{15{rrec.x[16]}}, rrec.x};
            res_y    = {{15{rrec.y[16]}}, rrec.y};
        end

        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_BOUNDS_X) begin
                n_head    = '0;
                n_tail    = '0;
                n_bound_x = cfg_bound;
                if ({1'b0, r_cur_x} >= cfg_bound) begin
                    n_cur_x = 16'(cfg_bound - 17'd1);
                end
            end else if (i_cfg_index == CFG_BOUNDS_Y) begin
                n_head    = '0;
                n_tail    = '0;
                n_bound_y = cfg_bound;
                if ({1'b0, r_cur_y} >= cfg_bound) begin
                    n_cur_y = 16'(cfg_bound - 17'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bound_x   <= DEF_BOUND_X;
            r_bound_y   <= DEF_BOUND_Y;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_msum_x    <= '0;
            r_msum_y    <= '0;
            r_wsum_x    <= '0;
            r_wsum_y    <= '0;
            r_held      <= '0;
            r_pressed   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bound_x <= n_bound_x;
            r_bound_y <= n_bound_y;
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_msum_x  <= n_msum_x;
            r_msum_y  <= n_msum_y;
            r_wsum_x  <= n_wsum_x;
            r_wsum_y  <= n_wsum_y;
            r_held    <= n_held;
            r_pressed <= n_pressed;
            r_head    <= n_head;
            r_tail    <= n_tail;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status <= res_status;
            r_kind   <= res_kind;
            r_time   <= res_time;
            r_x      <= res_x;
            r_y      <= res_y;
            r_btn    <= res_btn;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_event_kind  = r_kind;
    assign o_event_time  = r_time;
    assign o_out_x       = r_x;
    assign o_out_y       = r_y;
    assign o_out_buttons = r_btn;

    // a queue read is only in flight right after a peek/get request
    a_read_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> $past(go_read))
        else $error("queue read without peek/get request");

    // the read cycle always produces a result
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> r_out_valid)
        else $error("queue read produced no result");

    // a stored post leaves the queue non-empty
    a_post_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_post && !q_full && !i_cfg_valid) |=> (r_head != r_tail))
        else $error("accepted post left queue empty");

endmodule

// ----- tb/mouse_event_tracker_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_event_tracker_check
// Watches the request, result and register channels of the mouse event
// tracker, keeps its own copy of cursor, sums, button masks and the event
// queue, and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module mouse_event_tracker_check
    import met_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_operation,
    input  logic [16:0] i_value_x,
    input  logic [16:0] i_value_y,
    input  logic [7:0]  i_button_mask,
    input  logic [31:0] i_stamp_ms,
    input  logic [31:0] i_now_ms,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_status,
    input  logic [2:0]  i_event_kind,
    input  logic [31:0] i_event_time,
    input  logic [31:0] i_out_x,
    input  logic [31:0] i_out_y,
    input  logic [7:0]  i_out_buttons,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,

    output int          o_fail_count,
    output int          o_pending_count
);

    typedef struct packed {
        logic        status;
        logic [2:0]  kind;
        logic [31:0] etime;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  buttons;
    } t_result;

    logic [31:0] bound_x, bound_y;
    logic [31:0] cur_x, cur_y;
    logic [31:0] motion_x, motion_y;
    logic [31:0] wheel_x, wheel_y;
    logic [7:0]  held_mask, pressed_mask;
    t_record     event_log[$];
    t_result     expected_q[$];
    int          fail_count;

    function automatic logic [31:0] widen17(input logic [16:0] v);
        return {{15{v[16]}}, v};
    endfunction

    function automatic logic [31:0] legal_bound(input logic [16:0] v);
        if (v == '0) begin
            return 32'd1;
        end
        if (v > BOUND_MAX) begin
            return 32'(BOUND_MAX);
        end
        return 32'(v);
    endfunction

    // updates the tracked state for one request and returns its result
    function automatic t_result track_request(
        input logic [3:0]  op,
        input logic [16:0] raw_x,
        input logic [16:0] raw_y,
        input logic [7:0]  mask,
        input logic [31:0] stamp_in,
        input logic [31:0] now
    );
        t_result     r;
        t_record     rec;
        logic [31:0] vx, vy, nx, ny;

        r   = '0;
        rec = '0;
        vx  = widen17(raw_x);
        vy  = widen17(raw_y);
        if (op <= OP_WHEEL) begin
            if (event_log.size() >= QUEUE_DEPTH - 1) begin
                r.status = 1'b1;
            end else begin
                rec.stamp = (stamp_in == '0) ? now : stamp_in;
                case (op)
                    OP_POSITION: begin
                        rec.kind = EV_POSITION;
                        motion_x += vx - cur_x;
                        motion_y += vy - cur_y;
                        // negatives compare as huge unsigned and clamp high
                        if (vx >= bound_x) vx = bound_x - 32'd1;
                        if (vy >= bound_y) vy = bound_y - 32'd1;
                        cur_x = vx;
                        cur_y = vy;
                        rec.x = vx[16:0];
                        rec.y = vy[16:0];
                    end
                    OP_MOTION: begin
                        rec.kind = EV_MOTION;
                        motion_x += vx;
                        motion_y += vy;
                        nx = cur_x + vx;
                        ny = cur_y + vy;
                        if (nx >= bound_x) nx = vx[31] ? 32'd0 : bound_x - 32'd1;
                        if (ny >= bound_y) ny = vy[31] ? 32'd0 : bound_y - 32'd1;
                        cur_x = nx;
                        cur_y = ny;
                        rec.x = raw_x;
                        rec.y = raw_y;
                    end
                    OP_DOWN, OP_UP: begin
                        rec.kind    = (op == OP_DOWN) ? EV_DOWN : EV_UP;
                        rec.x       = cur_x[16:0];
                        rec.y       = cur_y[16:0];
                        rec.buttons = mask;
                        if (op == OP_DOWN) begin
                            held_mask    |= mask;
                            pressed_mask |= mask;
                        end else begin
                            held_mask &= ~mask;
                        end
                    end
                    default: begin
                        rec.kind = EV_WHEEL;
                        wheel_x += vx;
                        wheel_y += vy;
                        rec.x = raw_x;
                        rec.y = raw_y;
                    end
                endcase
                event_log.push_back(rec);
            end
        end else if (op <= OP_WHEELY) begin
            event_log.delete();
            case (op)
                OP_HELD: r.buttons = held_mask;
                OP_PRESSED: begin
                    r.buttons    = pressed_mask;
                    pressed_mask = '0;
                end
                OP_POS: begin
                    r.x = cur_x;
                    r.y = cur_y;
                end
                OP_DELTA: begin
                    r.x      = motion_x;
                    r.y      = motion_y;
                    motion_x = '0;
                    motion_y = '0;
                end
                OP_WHEELX: begin
                    r.x     = wheel_x;
                    wheel_x = '0;
                end
                default: begin
                    // vertical wheel comes back on the x field
                    r.x     = wheel_y;
                    wheel_y = '0;
                end
            endcase
        end else if (op <= OP_GET) begin
            if (event_log.size() == 0) begin
                r.status = 1'b1;
            end else begin
                rec       = event_log[0];
                r.kind    = rec.kind;
                r.etime   = rec.stamp;
                r.buttons = rec.buttons;
                r.x       = widen17(rec.x);
                r.y       = widen17(rec.y);
                if (op == OP_GET) void'(event_log.pop_front());
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got, want;

        if (!i_rst_n) begin
            bound_x      = 32'(DEF_BOUND_X);
            bound_y      = 32'(DEF_BOUND_Y);
            cur_x        = '0;
            cur_y        = '0;
            motion_x     = '0;
            motion_y     = '0;
            wheel_x      = '0;
            wheel_y      = '0;
            held_mask    = '0;
            pressed_mask = '0;
            fail_count   = 0;
            event_log.delete();
            expected_q.delete();
        end else begin
            // a result never leaves on the edge its request enters, so pop first
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_event_kind, i_event_time, i_out_x, i_out_y,
                       i_out_buttons};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with nothing pending: st=%0d kind=%0d",
                                 $realtime, i_status, i_event_kind);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.kind !== want.kind ||
                        got.etime !== want.etime || got.x !== want.x ||
                        got.y !== want.y || got.buttons !== want.buttons) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch exp st=%0d kind=%0d time=%h x=%h y=%h btn=%h",
                                     $realtime, want.status, want.kind, want.etime,
                                     want.x, want.y, want.buttons);
                            $display("%0t:          got st=%0d kind=%0d time=%h x=%h y=%h btn=%h",
                                     $realtime, got.status, got.kind, got.etime,
                                     got.x, got.y, got.buttons);
                        end
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BOUNDS_X: begin
                        event_log.delete();
                        bound_x = legal_bound(i_cfg_data);
                        if (cur_x >= bound_x) cur_x = bound_x - 32'd1;
                    end
                    CFG_BOUNDS_Y: begin
                        event_log.delete();
                        bound_y = legal_bound(i_cfg_data);
                        if (cur_y >= bound_y) cur_y = bound_y - 32'd1;
                    end
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(track_request(i_operation, i_value_x, i_value_y,
                                                   i_button_mask, i_stamp_ms, i_now_ms));
            end
        end
        o_fail_count    <= fail_count;
        o_pending_count <= expected_q.size();
    end

endmodule

// ----- tb/mouse_event_tracker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_event_tracker_test
// Drives directed and random mouse events, reads and queue accesses into the
// tracker across several bound settings and idle/stall patterns, including a
// long result hold-off, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module mouse_event_tracker_test;
    import met_pkg::*;

    localparam int          CYCLE_LIMIT     = 500000;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          PHASE_REQUESTS  = 275;
    localparam logic [3:0]  OP_UNUSED_FIRST = 4'd13;
    localparam logic [3:0]  OP_UNUSED_LAST  = 4'd15;
    localparam logic [1:0]  CFG_UNUSED      = 2'd2;

    logic               i_clk = 1'b0;
    logic               i_rst_n;

    logic               i_in_valid;
    logic               o_in_stall;
    logic [3:0]         i_operation;
    logic signed [16:0] i_value_x;
    logic signed [16:0] i_value_y;
    logic [7:0]         i_button_mask;
    logic [31:0]        i_stamp_ms;
    logic [31:0]        i_now_ms;

    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_status;
    logic [2:0]         o_event_kind;
    logic [31:0]        o_event_time;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic [7:0]         o_out_buttons;

    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [16:0]        i_cfg_data;

    int fail_count;
    int pending_count;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req_cnt  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int sent          = 0;

    always #2 i_clk = ~i_clk;

    mouse_event_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_value_x     (i_value_x),
        .i_value_y     (i_value_y),
        .i_button_mask (i_button_mask),
        .i_stamp_ms    (i_stamp_ms),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_event_kind  (o_event_kind),
        .o_event_time  (o_event_time),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_buttons (o_out_buttons),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    mouse_event_tracker_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_value_x       (i_value_x),
        .i_value_y       (i_value_y),
        .i_button_mask   (i_button_mask),
        .i_stamp_ms      (i_stamp_ms),
        .i_now_ms        (i_now_ms),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_event_kind    (o_event_kind),
        .i_event_time    (o_event_time),
        .i_out_x         (o_out_x),
        .i_out_y         (o_out_y),
        .i_out_buttons   (o_out_buttons),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // result side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_seen != hold_req_cnt) begin
            hold_seen   <= hold_req_cnt;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [16:0] pick_coord();
        int v;
        case ($urandom_range(7))
            0: v = -32768;
            1: v = 65535;
            2: v = 0;
            3: v = int'($urandom_range(64)) - 32;
            default: v = int'($urandom_range(98303)) - 32768;
        endcase
        return v[16:0];
    endfunction

    function automatic logic signed [16:0] pick_nudge();
        int v;
        v = int'($urandom_range(64)) - 32;
        return v[16:0];
    endfunction

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(7))
            0, 1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(input logic [3:0] op, input logic signed [16:0] vx,
                                input logic signed [16:0] vy, input logic [7:0] mask,
                                input logic [31:0] stamp, input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_value_x     <= vx;
        i_value_y     <= vy;
        i_button_mask <= mask;
        i_stamp_ms    <= stamp;
        i_now_ms      <= now;
        do @(posedge i_clk); while (o_in_stall);
        if (op <= OP_GET) sent++;
    endtask

    task automatic send_post();
        logic [3:0]         op;
        logic signed [16:0] vx, vy;

        op = 4'($urandom_range(OP_WHEEL, OP_POSITION));
        if (op == OP_MOTION && $urandom_range(1) == 1) begin
            vx = pick_nudge();
            vy = pick_nudge();
        end else begin
            vx = pick_coord();
            vy = pick_coord();
        end
        send_request(op, vx, vy, 8'($urandom_range(255)), pick_stamp(), $urandom());
    endtask

    // non-post request with random don't-care payload
    task automatic send_query(input logic [3:0] op);
        send_request(op, pick_coord(), pick_coord(), 8'($urandom_range(255)),
                     pick_stamp(), $urandom());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int target;
        int pick;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = '0;
        i_value_x     = '0;
        i_value_y     = '0;
        i_button_mask = '0;
        i_stamp_ms    = '0;
        i_now_ms      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty queue, clamps, edges, every read, unused codes
        send_request(OP_PEEK, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_GET, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_DOWN, 17'sd0, 17'sd0, 8'hFF, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_POSITION, 17'sd65535, 17'sd65535, 8'h00, 32'hFFFF_FFFF, 32'd5);
        send_request(OP_POSITION, -17'sd32768, -17'sd1, 8'h00, 32'd7, 32'd0);
        send_request(OP_POSITION, 17'sd0, 17'sd0, 8'h00, 32'd1, 32'd9);
        send_request(OP_MOTION, -17'sd32768, -17'sd32768, 8'h00, 32'd0, 32'd11);
        send_request(OP_MOTION, 17'sd65535, 17'sd65535, 8'h00, 32'd12, 32'd0);
        send_request(OP_MOTION, -17'sd5, 17'sd3, 8'h00, 32'd13, 32'd0);
        send_request(OP_UP, 17'sd0, 17'sd0, 8'h55, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_WHEEL, 17'sd65535, -17'sd32768, 8'h00, 32'd0, 32'h8000_0000);
        send_request(OP_WHEEL, -17'sd1, 17'sd1, 8'h00, 32'd15, 32'd0);
        send_request(OP_PEEK, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_GET, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_GET, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_HELD, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_PRESSED, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_PRESSED, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_POS, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_DELTA, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_DELTA, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_WHEELX, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_WHEELY, 17'sd0, 17'sd0, 8'h00, 32'd0, 32'd0);
        send_request(OP_UNUSED_FIRST, -17'sd1, -17'sd1, 8'hFF, 32'hFFFF_FFFF, 32'd1);
        send_request(OP_UNUSED_LAST, 17'sd1, 17'sd1, 8'h01, 32'd1, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                1: begin
                    write_register(CFG_BOUNDS_X, 17'd0);
                    write_register(CFG_BOUNDS_Y, 17'd1);
                end
                2: begin
                    write_register(CFG_BOUNDS_X, 17'd65536);
                    write_register(CFG_BOUNDS_Y, 17'h1FFFF);
                end
                3: begin
                    write_register(CFG_BOUNDS_X, 17'($urandom_range(2000, 2)));
                    write_register(CFG_BOUNDS_Y, 17'($urandom_range(2000, 2)));
                    write_register(CFG_UNUSED, 17'($urandom()));
                end
                4: begin
                    write_register(CFG_BOUNDS_X, 17'd65535);
                    write_register(CFG_BOUNDS_Y, 17'd2);
                end
                5: begin
                    write_register(CFG_BOUNDS_X, DEF_BOUND_X);
                    write_register(CFG_BOUNDS_Y, DEF_BOUND_Y);
                end
                default: ;
            endcase

            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 70; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 70; end
                default: begin send_idle_pct = 38; stall_pct <= 38; end
            endcase
            // back-pressure test: results held while requests keep coming
            if (phase == 2) hold_req_cnt <= hold_req_cnt + 1;

            target = sent + PHASE_REQUESTS;
            while (sent < target) begin
                if ($urandom_range(99) < 35) begin
                    // burst of posts, long enough to hit a full queue
                    repeat ($urandom_range(36, 20)) send_post();
                    repeat ($urandom_range(10, 1)) send_query(4'($urandom_range(OP_GET, OP_PEEK)));
                end else begin
                    repeat ($urandom_range(8, 1)) begin
                        pick = $urandom_range(99);
                        if (pick < 45) begin
                            send_post();
                        end else if (pick < 68) begin
                            send_query(4'($urandom_range(OP_GET, OP_PEEK)));
                        end else if (pick < 95) begin
                            send_query(4'($urandom_range(OP_WHEELY, OP_HELD)));
                        end else begin
                            send_query(4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)));
                        end
                    end
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
